>>> hdl/plars_pkg.sv
// ----------------------------------------------------------------------------
// Per-line auto-report scheduler package
// Request codes and the item types that travel on the two channels.
// ----------------------------------------------------------------------------
package plars_pkg;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_CONFIG  = 2'd1,
    REQ_SUSPEND = 2'd2,
    REQ_RESUME  = 2'd3
  } req_type_e;

  localparam logic [7:0] MODE_OUTPUT = 8'd1;

  typedef struct packed {
    req_type_e   req_type;
    logic [7:0]  line_index;
    logic [7:0]  line_mode;
    logic [31:0] period_ms;
    logic        link_ready;
    logic [15:0] input_levels;
  } req_t;

  typedef struct packed {
    logic [31:0] report_time;
    logic [15:0] line_levels;
    logic [15:0] direction_mask;
  } rsp_t;

endpackage

>>> hdl/per_line_auto_report_scheduler_top.sv
// ----------------------------------------------------------------------------
// Per-line auto-report scheduler
// Millisecond counter with a report period and due time for each line.
// ----------------------------------------------------------------------------
// The block takes one item in every cycle while its input side is not
// stalled, and offers a snapshot if the item is a tick that finds a line due
// while the link is ready and reports are not suspended: the item is held in
// the input register while the per-line due compares and re-arm adders feed
// the result register. All lines are checked in parallel in that single
// stage. A stalled result holds the input register, and the input side
// stalls only while both registers are full and the result is stalled.
module per_line_auto_report_scheduler_top #(
  parameter int LINES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  plars_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output plars_pkg::rsp_t out_rsp_o
);
  import plars_pkg::*;

  req_t              item_q;
  logic              item_valid_q;
  logic              proc_en;

  logic [31:0]       now_q, now_d;
  logic [31:0]       inc_q, inc_d;
  logic              susp_q, susp_d;
  logic [LINES-1:0]  is_out_q, is_out_d;
  logic [31:0]       period_q [LINES];
  logic [31:0]       period_d [LINES];
  logic [31:0]       due_q    [LINES];
  logic [31:0]       due_d    [LINES];
  logic [31:0]       diff     [LINES];
  logic              fire;
  logic              cfg_ok;
  logic [31:0]       dir_wide;

  rsp_t              rsp_q;
  logic              out_valid_q;

  assign proc_en    = item_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = item_valid_q && !proc_en;
  assign cfg_ok     = (item_q.line_index < 8'(LINES)) && (item_q.line_mode <= MODE_OUTPUT);
  assign dir_wide   = 32'(is_out_q);

  always_comb begin
    now_d    = now_q;
    inc_d    = inc_q;
    susp_d   = susp_q;
    is_out_d = is_out_q;
    fire     = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      period_d[i] = period_q[i];
      due_d[i]    = due_q[i];
      diff[i]     = inc_q - due_q[i];
    end
    if (proc_en) begin
      unique case (item_q.req_type)
        REQ_TICK: begin
          now_d = inc_q;
          inc_d = inc_q + 32'd1;
          if (item_q.link_ready && !susp_q) begin
            for (int i = 0; i < LINES; i++) begin
              if (period_q[i] != 32'd0 && !diff[i][31]) begin
                due_d[i] = inc_q + period_q[i];
                fire     = 1'b1;
              end
            end
          end
        end
        REQ_CONFIG: begin
          for (int i = 0; i < LINES; i++) begin
            if (cfg_ok && item_q.line_index == 8'(i)) begin
              is_out_d[i] = (item_q.line_mode == MODE_OUTPUT);
              period_d[i] = item_q.period_ms;
              due_d[i]    = (item_q.period_ms != 32'd0) ? now_q + item_q.period_ms : 32'd0;
            end
          end
        end
        REQ_SUSPEND: begin
          susp_d = 1'b1;
        end
        REQ_RESUME: begin
          for (int i = 0; i < LINES; i++) begin
            if (period_q[i] != 32'd0) begin
              due_d[i] = now_q + period_q[i];
            end
          end
          susp_d = 1'b0;
        end
        default: begin
          susp_d = susp_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      now_q        <= 32'd0;
      inc_q        <= 32'd1;
      susp_q       <= 1'b0;
      is_out_q     <= '0;
      for (int i = 0; i < LINES; i++) begin
        period_q[i] <= 32'd0;
        due_q[i]    <= 32'd0;
      end
    end else begin
      if (!in_stall_o) begin
        item_valid_q <= in_valid_i;
      end
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= proc_en && fire;
      end
      now_q    <= now_d;
      inc_q    <= inc_d;
      susp_q   <= susp_d;
      is_out_q <= is_out_d;
      for (int i = 0; i < LINES; i++) begin
        period_q[i] <= period_d[i];
        due_q[i]    <= due_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_req_i;
    end
    if (proc_en && fire) begin
      rsp_q.report_time    <= inc_q;
      rsp_q.line_levels    <= item_q.input_levels;
      rsp_q.direction_mask <= dir_wide[15:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

>>> hdl/plars_checker.sv
// ----------------------------------------------------------------------------
// Per-line auto-report scheduler checker
// Port-level properties of the scheduler, bound to its top level.
// ----------------------------------------------------------------------------
module plars_checker #(
  parameter int LINES = 16
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input plars_pkg::req_t in_req_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input plars_pkg::rsp_t out_rsp_o
);
  import plars_pkg::*;

  logic [47:0] mask_wide;
  assign mask_wide = {32'd0, out_rsp_o.direction_mask};

  // The input side is held back only by a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // A new result can only appear after the input side was open.
  a_rise_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_stall_o))
    else $error("result appeared after a stalled input cycle");

  // Lines that do not exist never show as outputs.
  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((mask_wide >> LINES) == 48'd0))
    else $error("direction mask names a line that does not exist");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_req_i)))
    else $error("stalled input item changed");

endmodule

bind per_line_auto_report_scheduler_top plars_checker #(.LINES(LINES)) u_plars_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
